// ===== rtl/ias_instruction_cycle_core_macros.svh =====
// assertion macros for the ias instruction cycle core
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef IAS_INSTRUCTION_CYCLE_CORE_MACROS_SVH
`define IAS_INSTRUCTION_CYCLE_CORE_MACROS_SVH

// same-cycle implication
`define IAS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ias core assertion failed");

// next-cycle implication
`define IAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ias core assertion failed");

`endif

// ===== rtl/ias_pkg.sv =====
// shared types and codes for the ias instruction cycle core
// no dependencies
`timescale 1ns / 1ps

package ias_pkg;

    localparam int ADDR_BITS_DEF = 12;
    localparam int WORD_W        = 64;
    localparam int PC_W          = 12;
    localparam int HALF_W        = 20;
    localparam int ITER_W        = 6;
    localparam logic [11:0] START_RESET = 12'd100;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    // status codes
    localparam logic [2:0] ST_EXEC    = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_DIVZ    = 3'd3;
    localparam logic [2:0] ST_WRITTEN = 3'd4;
    localparam logic [2:0] ST_READ    = 3'd5;

    // opcodes
    localparam logic [7:0] OP_LOAD   = 8'd1;
    localparam logic [7:0] OP_NEG    = 8'd2;
    localparam logic [7:0] OP_ABS    = 8'd3;
    localparam logic [7:0] OP_NABS   = 8'd4;
    localparam logic [7:0] OP_ADD    = 8'd5;
    localparam logic [7:0] OP_SUB    = 8'd6;
    localparam logic [7:0] OP_ADDABS = 8'd7;
    localparam logic [7:0] OP_SUBABS = 8'd8;
    localparam logic [7:0] OP_LDMQ   = 8'd9;
    localparam logic [7:0] OP_MQAC   = 8'd10;
    localparam logic [7:0] OP_MUL    = 8'd11;
    localparam logic [7:0] OP_DIV    = 8'd12;
    localparam logic [7:0] OP_JMPL   = 8'd13;
    localparam logic [7:0] OP_JMPR   = 8'd14;
    localparam logic [7:0] OP_JGEL   = 8'd15;
    localparam logic [7:0] OP_JGER   = 8'd16;
    localparam logic [7:0] OP_STL    = 8'd18;
    localparam logic [7:0] OP_STR    = 8'd19;
    localparam logic [7:0] OP_SHL    = 8'd20;
    localparam logic [7:0] OP_SHR    = 8'd21;
    localparam logic [7:0] OP_STORE  = 8'd33;

    // request to the shared adder
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic              sub;
    } t_alu_req;

endpackage

// ===== rtl/ias_instruction_cycle_core.sv =====
// top level of the ias instruction cycle core: sequencer, memory, registers
// depends on ias_pkg, ias_alu and ias_instruction_cycle_core_macros.svh
`timescale 1ns / 1ps

// IAS-style accumulator machine with a 2^ADDR_BITS x 64 word memory.
// a word is taken on i_start while o_busy is low; its result appears for
// exactly one cycle with o_done and cannot be stalled, so it must be taken
// then. after reset a clearing pass zeroes the memory, one word a cycle,
// with o_busy high throughout; configuration writes are always taken
// (o_cfg_ready is tied high) and load the program counter.
// steps per word: a write needs no further state, a read passes S_RDW, a step
//   fetches unless an instruction is buffered, then decodes and executes (a
//   zero word halts at fetch); mul and div add their bit loop and fix-up states.
// multiply and divide run one bit per cycle through the single shared
// 64-bit adder, which also does add, subtract, negate and abs.
module ias_instruction_cycle_core #(
    parameter int ADDR_BITS = ias_pkg::ADDR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [1:0]                   i_req_type,
    input  logic [11:0]                  i_address,
    input  logic [ias_pkg::WORD_W-1:0]   i_write_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [11:0]                  i_cfg_data,
    output logic                         o_done,
    output logic [2:0]                   o_status,
    output logic [7:0]                   o_opcode,
    output logic [ias_pkg::PC_W-1:0]     o_pc,
    output logic [ias_pkg::WORD_W-1:0]   o_ac,
    output logic [ias_pkg::WORD_W-1:0]   o_mq,
    output logic [ias_pkg::WORD_W-1:0]   o_read_data
);
    import ias_pkg::*;

    localparam int MEM_WORDS = 1 << ADDR_BITS;

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_RDW   = 14'b00000000000100,
        S_FETW  = 14'b00000000001000,
        S_DEC   = 14'b00000000010000,
        S_EXEC  = 14'b00000000100000,
        S_MUL   = 14'b00000001000000,
        S_MC1   = 14'b00000010000000,
        S_MC2   = 14'b00000100000000,
        S_DA    = 14'b00001000000000,
        S_DB    = 14'b00010000000000,
        S_DIV   = 14'b00100000000000,
        S_DQ    = 14'b01000000000000,
        S_DR    = 14'b10000000000000
    } t_state;

    t_state                  r_state, n_state;
    logic [ADDR_BITS-1:0]    r_cnt, n_cnt;
    logic [ITER_W-1:0]       r_it, n_it;
    logic [ADDR_BITS-1:0]    r_pc, n_pc;
    logic [HALF_W-1:0]       r_ib, n_ib;
    logic [HALF_W-1:0]       r_instr, n_instr;
    logic [WORD_W-1:0]       r_ac, n_ac;
    logic [WORD_W-1:0]       r_mq, n_mq;
    logic [WORD_W-1:0]       r_a, n_a;
    logic [WORD_W-1:0]       r_b, n_b;
    logic [2*WORD_W-1:0]     r_p, n_p;
    logic                    r_sa, n_sa;
    logic                    r_sb, n_sb;
    logic                    r_done, n_done;
    logic [2:0]              r_status, n_status;
    logic [7:0]              r_opc, n_opc;
    logic [WORD_W-1:0]       r_rdata, n_rdata;
    logic [WORD_W-1:0]       r_q;

    logic [WORD_W-1:0]       r_mem [MEM_WORDS];
    logic                    mem_we;
    logic [ADDR_BITS-1:0]    mem_waddr;
    logic [WORD_W-1:0]       mem_wdata;
    logic [ADDR_BITS-1:0]    mem_raddr;

    t_alu_req                alu_req;
    logic [WORD_W-1:0]       alu_sum;
    logic                    alu_cout;

    logic [7:0]              opc;
    logic [ADDR_BITS-1:0]    iaddr;
    logic [WORD_W-1:0]       rem_sh;

    assign opc    = r_instr[HALF_W-1:12];
    assign iaddr  = r_instr[ADDR_BITS-1:0];
    assign rem_sh = {r_p[2*WORD_W-2:WORD_W], r_p[WORD_W-1]};

    ias_alu u_alu (
        .i_req  (alu_req),
        .o_sum  (alu_sum),
        .o_cout (alu_cout)
    );

    // main memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_it      = r_it;
        n_pc      = r_pc;
        n_ib      = r_ib;
        n_instr   = r_instr;
        n_ac      = r_ac;
        n_mq      = r_mq;
        n_a       = r_a;
        n_b       = r_b;
        n_p       = r_p;
        n_sa      = r_sa;
        n_sb      = r_sb;
        n_done    = 1'b0;
        n_status  = r_status;
        n_opc     = r_opc;
        n_rdata   = r_rdata;
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = '0;
        mem_raddr = r_pc;
        alu_req.x   = r_ac;
        alu_req.y   = '0;
        alu_req.sub = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + ADDR_BITS'(1);
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req_type)
                        REQ_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_address[ADDR_BITS-1:0];
                            mem_wdata = i_write_data;
                            n_done    = 1'b1;
                            n_status  = ST_WRITTEN;
                            n_opc     = '0;
                            n_rdata   = '0;
                        end
                        REQ_STEP: begin
                            if (r_ib != '0) begin
                                n_instr = r_ib;
                                n_ib    = '0;
                                n_pc    = r_pc + ADDR_BITS'(1);
                                n_state = S_DEC;
                            end else begin
                                n_state = S_FETW;
                            end
                        end
                        default: begin
                            // code three reads as well
                            mem_raddr = i_address[ADDR_BITS-1:0];
                            n_state   = S_RDW;
                        end
                    endcase
                end
            end
            S_RDW: begin
                n_done   = 1'b1;
                n_status = ST_READ;
                n_opc    = '0;
                n_rdata  = r_q;
                n_state  = S_IDLE;
            end
            S_FETW: begin
                if (r_q == '0) begin
                    n_done   = 1'b1;
                    n_status = ST_HALT;
                    n_opc    = '0;
                    n_rdata  = '0;
                    n_state  = S_IDLE;
                end else begin
                    if (r_q[39:20] == '0) begin
                        n_instr = r_q[19:0];
                        n_pc    = r_pc + ADDR_BITS'(1);
                    end else begin
                        n_instr = r_q[39:20];
                        if (r_q[19:0] != '0) begin
                            n_ib = r_q[19:0];
                        end else begin
                            n_pc = r_pc + ADDR_BITS'(1);
                        end
                    end
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                // operand read at the address field
                mem_raddr = iaddr;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                n_done   = 1'b1;
                n_status = ST_EXEC;
                n_opc    = opc;
                n_rdata  = '0;
                n_state  = S_IDLE;
                alu_req.y = r_q;
                unique case (opc)
                    OP_LOAD:   n_ac = r_q;
                    OP_NEG: begin
                        alu_req.x = '0;  alu_req.sub = 1'b1;       n_ac = alu_sum;
                    end
                    OP_ABS: begin
                        alu_req.x = '0;  alu_req.sub = r_q[63];    n_ac = alu_sum;
                    end
                    OP_NABS: begin
                        alu_req.x = '0;  alu_req.sub = !r_q[63];   n_ac = alu_sum;
                    end
                    OP_ADD:    n_ac = alu_sum;
                    OP_SUB: begin
                        alu_req.sub = 1'b1;                        n_ac = alu_sum;
                    end
                    OP_ADDABS: begin
                        alu_req.sub = r_q[63];                     n_ac = alu_sum;
                    end
                    OP_SUBABS: begin
                        alu_req.sub = !r_q[63];                    n_ac = alu_sum;
                    end
                    OP_LDMQ:   n_mq = r_q;
                    OP_MQAC:   n_ac = r_mq;
                    OP_MUL: begin
                        n_a     = r_ac;
                        n_b     = r_q;
                        n_p     = {{WORD_W{1'b0}}, r_q};
                        n_it    = '0;
                        n_done  = 1'b0;
                        n_state = S_MUL;
                    end
                    OP_DIV: begin
                        if (r_q == '0) begin
                            n_status = ST_DIVZ;
                        end else begin
                            n_sa    = r_ac[63];
                            n_sb    = r_q[63];
                            n_b     = r_q;
                            n_done  = 1'b0;
                            n_state = S_DA;
                        end
                    end
                    OP_JMPL: begin
                        n_ib = '0;  n_pc = iaddr;
                    end
                    OP_JGEL: begin
                        if (!r_ac[63]) begin
                            n_ib = '0;  n_pc = iaddr;
                        end
                    end
                    OP_JMPR: begin
                        n_ib = r_q[19:0];  n_pc = iaddr;
                    end
                    OP_JGER: begin
                        if (!r_ac[63]) begin
                            n_ib = r_q[19:0];  n_pc = iaddr;
                        end
                    end
                    OP_STL: begin
                        mem_we    = 1'b1;
                        mem_waddr = iaddr;
                        mem_wdata = {24'd0, r_q[39:32], r_ac[11:0], r_q[19:0]};
                    end
                    OP_STR: begin
                        mem_we    = 1'b1;
                        mem_waddr = iaddr;
                        mem_wdata = {24'd0, r_q[39:12], r_ac[11:0]};
                    end
                    OP_SHL:    n_ac = {r_ac[62:0], 1'b0};
                    OP_SHR:    n_ac = {r_ac[63], r_ac[63:1]};
                    OP_STORE: begin
                        mem_we    = 1'b1;
                        mem_waddr = iaddr;
                        mem_wdata = r_ac;
                    end
                    default:   n_status = ST_INVALID;
                endcase
            end
            S_MUL: begin
                // shift-add, one multiplier bit a cycle
                alu_req.x = r_p[2*WORD_W-1:WORD_W];
                alu_req.y = r_p[0] ? r_a : '0;
                n_p  = {alu_cout, alu_sum, r_p[WORD_W-1:1]};
                n_it = r_it + ITER_W'(1);
                if (r_it == '1) begin
                    n_state = S_MC1;
                end
            end
            S_MC1: begin
                // signed correction of the upper half
                alu_req.x   = r_p[2*WORD_W-1:WORD_W];
                alu_req.y   = r_a[63] ? r_b : '0;
                alu_req.sub = 1'b1;
                n_p     = {alu_sum, r_p[WORD_W-1:0]};
                n_state = S_MC2;
            end
            S_MC2: begin
                alu_req.x   = r_p[2*WORD_W-1:WORD_W];
                alu_req.y   = r_b[63] ? r_a : '0;
                alu_req.sub = 1'b1;
                n_ac     = {24'd0, alu_sum[15:0], r_p[63:40]};
                n_mq     = {24'd0, r_p[39:0]};
                n_done   = 1'b1;
                n_status = ST_EXEC;
                n_opc    = opc;
                n_rdata  = '0;
                n_state  = S_IDLE;
            end
            S_DA: begin
                alu_req.x   = '0;
                alu_req.y   = r_ac;
                alu_req.sub = r_ac[63];
                n_p     = {{WORD_W{1'b0}}, alu_sum};
                n_state = S_DB;
            end
            S_DB: begin
                alu_req.x   = '0;
                alu_req.y   = r_b;
                alu_req.sub = r_b[63];
                n_b     = alu_sum;
                n_it    = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle
                alu_req.x   = rem_sh;
                alu_req.y   = r_b;
                alu_req.sub = 1'b1;
                n_p  = {(alu_cout ? alu_sum : rem_sh), r_p[WORD_W-2:0], alu_cout};
                n_it = r_it + ITER_W'(1);
                if (r_it == '1) begin
                    n_state = S_DQ;
                end
            end
            S_DQ: begin
                alu_req.x   = '0;
                alu_req.y   = r_p[WORD_W-1:0];
                alu_req.sub = r_sa ^ r_sb;
                n_mq    = alu_sum;
                n_state = S_DR;
            end
            S_DR: begin
                alu_req.x   = '0;
                alu_req.y   = r_p[2*WORD_W-1:WORD_W];
                alu_req.sub = r_sa;
                n_ac     = alu_sum;
                n_done   = 1'b1;
                n_status = ST_EXEC;
                n_opc    = opc;
                n_rdata  = '0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write loads the program counter
        if (i_cfg_valid) begin
            n_pc = i_cfg_data[ADDR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_it    <= '0;
            r_pc    <= ADDR_BITS'(START_RESET);
            r_ib    <= '0;
            r_ac    <= '0;
            r_mq    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_it    <= n_it;
            r_pc    <= n_pc;
            r_ib    <= n_ib;
            r_ac    <= n_ac;
            r_mq    <= n_mq;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_instr  <= n_instr;
        r_a      <= n_a;
        r_b      <= n_b;
        r_p      <= n_p;
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_status <= n_status;
        r_opc    <= n_opc;
        r_rdata  <= n_rdata;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_opcode    = r_opc;
    assign o_pc        = PC_W'(r_pc);
    assign o_ac        = r_ac;
    assign o_mq        = r_mq;
    assign o_read_data = r_rdata;

`include "ias_instruction_cycle_core_macros.svh"

    `IAS_ASSERT_IMPL(a_done_idle, o_done, !o_busy)
    `IAS_ASSERT_NEXT(a_accept_moves, i_start && !o_busy, o_busy || o_done)
    `IAS_ASSERT_IMPL(a_halt_no_opc, o_done && (o_status == ST_HALT), o_opcode == '0)

endmodule

// ===== rtl/ias_alu.sv =====
// shared 64-bit add/subtract unit with carry out
// depends on ias_pkg
`timescale 1ns / 1ps

module ias_alu (
    input  ias_pkg::t_alu_req              i_req,
    output logic [ias_pkg::WORD_W-1:0]     o_sum,
    output logic                           o_cout
);
    import ias_pkg::*;

    logic [WORD_W:0] full;

    // carry out high on subtract means x >= y
    assign full   = {1'b0, i_req.x} + {1'b0, (i_req.sub ? ~i_req.y : i_req.y)}
                  + {{WORD_W{1'b0}}, i_req.sub};
    assign o_sum  = full[WORD_W-1:0];
    assign o_cout = full[WORD_W];

endmodule
